// ===== design/ipv4p_pkg.sv =====
// Shared types and constants for the IPv4 dotted-address parser.
package ipv4p_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned TotalW   = 3;
  localparam int unsigned ResultW  = 1 + AddrW + TotalW;
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

  localparam logic [AddrW-1:0] LimitOnePart   = 32'h00ff_ffff;
  localparam logic [AddrW-1:0] LimitTwoParts  = 32'h0000_ffff;
  localparam logic [AddrW-1:0] LimitLastPart  = 32'h0000_00ff;
  localparam logic [AddrW-1:0] LimitEarlyPart = 32'h0000_00ff;

  typedef enum logic [1:0] {
    PH_START,
    PH_ZERO,
    PH_DIGITS,
    PH_TRAIL
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_OCT,
    RADIX_HEX
  } radix_t;

  // Decoded view of one incoming character.
  typedef struct packed {
    logic       term;
    logic       dec_digit;
    logic       hex_letter;
    logic       zero_char;
    logic       x_char;
    logic       dot;
    logic       blank;
    logic [3:0] digit;
  } char_class_t;

  typedef struct packed {
    logic [TotalW-1:0] part_total;
    logic [AddrW-1:0]  address;
    logic              ok;
  } result_t;

endpackage

// ===== design/ipv4p_char_class.sv =====
// Character decoder: classifies one string byte and gives its digit value.
module ipv4p_char_class
  import ipv4p_pkg::*;
(
  input  logic [ByteW-1:0] text_byte,
  output char_class_t      cls
);

  always_comb begin
    cls            = '0;
    cls.term       = (text_byte == 8'h00);
    cls.dec_digit  = (text_byte >= 8'h30) && (text_byte <= 8'h39);
    cls.zero_char  = (text_byte == 8'h30);
    cls.x_char     = (text_byte == 8'h78) || (text_byte == 8'h58);
    cls.dot        = (text_byte == 8'h2e);
    cls.blank      = (text_byte == 8'h20) || ((text_byte >= 8'h09) && (text_byte <= 8'h0d));
    if (cls.dec_digit) begin
      cls.digit = 4'(text_byte - 8'h30);
    end else if ((text_byte >= 8'h61) && (text_byte <= 8'h66)) begin
      cls.hex_letter = 1'b1;
      cls.digit      = 4'(text_byte - 8'h57);
    end else if ((text_byte >= 8'h41) && (text_byte <= 8'h46)) begin
      cls.hex_letter = 1'b1;
      cls.digit      = 4'(text_byte - 8'h37);
    end
  end

endmodule

// ===== design/ipv4p_part_fsm.sv =====
// Parser state machine: per-byte part accumulation and result assembly.
module ipv4p_part_fsm
  import ipv4p_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  char_class_t cls,
  output logic        result_push,
  output result_t     result
);

  phase_t           phase, phase_next;
  radix_t           radix, radix_next;
  logic [AddrW-1:0] part_value, part_value_next;
  logic [1:0]       parts_seen, parts_seen_next;
  logic             failed, failed_next;
  logic [7:0]       earlier [3];
  logic             store_part;

  logic [AddrW-1:0] shifted;
  radix_t           eff_radix;
  logic             take_digit;

  // Digit context: at the start of a part the radix is always decimal.
  always_comb begin
    eff_radix  = (phase == PH_START) ? RADIX_DEC : radix;
    take_digit = cls.dec_digit || (cls.hex_letter && (eff_radix == RADIX_HEX));
    unique case (eff_radix)
      RADIX_OCT: shifted = part_value << 3;
      RADIX_HEX: shifted = part_value << 4;
      default:   shifted = (part_value << 3) + (part_value << 1);
    endcase
  end

  always_comb begin
    phase_next      = phase;
    radix_next      = radix;
    part_value_next = part_value;
    parts_seen_next = parts_seen;
    failed_next     = failed;
    store_part      = 1'b0;
    if (step) begin
      if (cls.term) begin
        phase_next      = PH_START;
        radix_next      = RADIX_DEC;
        part_value_next = '0;
        parts_seen_next = '0;
        failed_next     = 1'b0;
      end else if (!failed && (phase != PH_TRAIL)) begin
        if ((phase == PH_START) && cls.zero_char) begin
          part_value_next = '0;
          radix_next      = RADIX_OCT;
          phase_next      = PH_ZERO;
        end else if ((phase == PH_ZERO) && cls.x_char) begin
          radix_next = RADIX_HEX;
          phase_next = PH_DIGITS;
        end else begin
          radix_next = eff_radix;
          priority if (take_digit) begin
            part_value_next = shifted + AddrW'(cls.digit);
            phase_next      = PH_DIGITS;
          end else if (cls.dot) begin
            if ((parts_seen == 2'd3) || (part_value > LimitEarlyPart)) begin
              failed_next = 1'b1;
            end else begin
              store_part      = 1'b1;
              parts_seen_next = parts_seen + 2'd1;
              part_value_next = '0;
              radix_next      = RADIX_DEC;
              phase_next      = PH_START;
            end
          end else if (cls.blank) begin
            phase_next = PH_TRAIL;
          end else begin
            failed_next = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    logic             fits;
    logic [AddrW-1:0] high_bytes;
    unique case (parts_seen)
      2'd0: begin
        fits       = 1'b1;
        high_bytes = '0;
      end
      2'd1: begin
        fits       = (part_value <= LimitOnePart);
        high_bytes = {earlier[0], 24'h0};
      end
      2'd2: begin
        fits       = (part_value <= LimitTwoParts);
        high_bytes = {earlier[0], earlier[1], 16'h0};
      end
      default: begin
        fits       = (part_value <= LimitLastPart);
        high_bytes = {earlier[0], earlier[1], earlier[2], 8'h0};
      end
    endcase
    result_push       = step && cls.term;
    result.ok         = !failed && fits;
    result.address    = result.ok ? (part_value | high_bytes) : '0;
    result.part_total = TotalW'(parts_seen) + TotalW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      radix      <= RADIX_DEC;
      part_value <= '0;
      parts_seen <= '0;
      failed     <= 1'b0;
    end else begin
      phase      <= phase_next;
      radix      <= radix_next;
      part_value <= part_value_next;
      parts_seen <= parts_seen_next;
      failed     <= failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_part) begin
      earlier[parts_seen] <= part_value[7:0];
    end
  end

endmodule

// ===== design/ipv4p_out_buf.sv =====
// Two-entry result buffer that decouples the parser from the output stream.
module ipv4p_out_buf
  import ipv4p_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    has_space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t    slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count, count_next;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign has_space = (count != 2'd2);
  assign out_data  = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/ipv4_dotted_address_parser_unit.sv =====
// Top level of the IPv4 dotted-address parser.
// Throughput: one string byte per cycle while s_tready is high; each byte updates the part
// registers, and the result is written into the result buffer on the terminator beat.
// The two-entry result buffer keeps bytes flowing while a result waits; input stalls only
// when both entries are full.
// Reset (synchronous, active high) clears the parse state and empties the result buffer.
module ipv4_dotted_address_parser_unit
  import ipv4p_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [ByteW-1:0]    s_tdata,   // [7:0] text_byte
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata    // [0] ok, [32:1] address, [35:33] part_total, rest 0
);

  char_class_t cls;
  logic        step;
  logic        result_push;
  result_t     result;
  result_t     out_result;

  assign step = s_tvalid && s_tready;

  ipv4p_char_class u_class (
    .text_byte (s_tdata),
    .cls       (cls)
  );

  ipv4p_part_fsm u_fsm (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .cls         (cls),
    .result_push (result_push),
    .result      (result)
  );

  ipv4p_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (result_push),
    .push_data (result),
    .has_space (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_result)
  );

  assign m_tdata = OutDataW'(out_result);

endmodule

// ===== design/ipv4p_checker.sv =====
// Port-level checker for the parser top level, with its bind statement.
module ipv4p_port_checker
  import ipv4p_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [ByteW-1:0]    s_tdata,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [OutDataW-1:0] m_tdata
);

  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_fail_zero : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> (m_tdata[32:1] == 32'h0))
    else $error("failed result carries a non-zero address");

  a_total_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[35:33] != 3'd0) && (m_tdata[35:33] <= 3'd4))
    else $error("part count out of range");

  a_term_gives_result : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata == 8'h00) |=> m_tvalid)
    else $error("terminator beat gave no result");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid straight after reset");

endmodule

bind ipv4_dotted_address_parser_unit ipv4p_port_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
